// ===== rtl/tked_pkg.sv =====
// Shared types and constants of the terminal key event decoder.
package tked_pkg;

    // Event codes carried on the result channel.
    typedef enum logic [4:0] {
        EV_NONE       = 5'd0,
        EV_UP         = 5'd1,
        EV_DOWN       = 5'd2,
        EV_RIGHT      = 5'd3,
        EV_LEFT       = 5'd4,
        EV_CLICK      = 5'd5,
        EV_QUIT       = 5'd6,
        EV_SAVE       = 5'd7,
        EV_UNDO       = 5'd8,
        EV_REFRESH    = 5'd9,
        EV_COPY       = 5'd10,
        EV_CUT        = 5'd11,
        EV_PASTE      = 5'd12,
        EV_SELECTALL  = 5'd13,
        EV_SEARCH     = 5'd14,
        EV_NEXT       = 5'd15,
        EV_PREV       = 5'd16,
        EV_REDO       = 5'd17,
        EV_DELBACK    = 5'd18,
        EV_NEWLINE    = 5'd19,
        EV_INSERT     = 5'd20,
        EV_SRCH_APPND = 5'd21,
        EV_SRCH_BACK  = 5'd22,
        EV_SUBMIT     = 5'd23,
        EV_CANCEL     = 5'd24
    } t_event_kind;

    // Control-key commands found by the front end.
    typedef enum logic [3:0] {
        CK_NONE,
        CK_QUIT,
        CK_SAVE,
        CK_UNDO,
        CK_REFRESH,
        CK_COPY,
        CK_CUT,
        CK_PASTE,
        CK_SELALL,
        CK_SEARCH,
        CK_NEXT,
        CK_PREV,
        CK_REDO
    } t_ctrl_key;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_MOUSE_EN  = 1'b0,
        CFG_INDENT_EN = 1'b1
    } t_cfg_idx;

    // Character constants.
    localparam logic [7:0] CH_ESC   = 8'h1b;
    localparam logic [7:0] CH_DEL   = 8'd127;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_LBR   = 8'h5b;
    localparam logic [7:0] CH_M     = 8'h4d;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [8:0] MOUSE_OFFSET = 9'd32;

    // Output payload widths.
    localparam int OUT_TDATA_W = 32;

    // Classified byte as passed from the front end to the back end.
    typedef struct packed {
        logic [7:0] ch;
        logic       is_esc;
        logic       is_crlf;
        logic       is_cr;
        logic       is_del;
        logic       is_print;
        logic       is_ins;
        logic       is_lbr;
        logic       is_m;
        logic       is_one;
        logic       is_semi;
        logic       is_two;
        logic [2:0] arrow;
        t_ctrl_key  ctrl;
    } t_byte_class;

    // One result item.
    typedef struct packed {
        t_event_kind kind;
        logic        extend_selection;
        logic [7:0]  char_value;
        logic [8:0]  click_col;
        logic [8:0]  click_row;
        logic        selection_active;
        logic        replace_selection;
        logic        indent_request;
    } t_result;

endpackage

// ===== rtl/tked_front.sv =====
// Front end: classifies each incoming terminal byte.
module tked_front (
    input  logic [7:0]           i_byte,
    output tked_pkg::t_byte_class o_class
);
    import tked_pkg::*;

    // Character flags and control-key lookup.
    always_comb begin
        o_class          = '0;
        o_class.ch       = i_byte;
        o_class.is_esc   = (i_byte == CH_ESC);
        o_class.is_cr    = (i_byte == CH_CR);
        o_class.is_crlf  = (i_byte == CH_CR) || (i_byte == CH_LF);
        o_class.is_del   = (i_byte == CH_BS) || (i_byte == CH_DEL);
        o_class.is_print = (i_byte >= CH_SPACE) && (i_byte < CH_DEL);
        o_class.is_ins   = (i_byte >= CH_SPACE) || (i_byte == CH_TAB) || (i_byte == CH_LF);
        o_class.is_lbr   = (i_byte == CH_LBR);
        o_class.is_m     = (i_byte == CH_M);
        o_class.is_one   = (i_byte == CH_ONE);
        o_class.is_semi  = (i_byte == CH_SEMI);
        o_class.is_two   = (i_byte == CH_TWO);
        o_class.arrow    = ((i_byte >= CH_A) && (i_byte <= CH_D))
                           ? (3'(i_byte - CH_A) + 3'd1) : 3'd0;
        unique case (i_byte)
            8'h11:   o_class.ctrl = CK_QUIT;
            8'h13:   o_class.ctrl = CK_SAVE;
            8'h15:   o_class.ctrl = CK_UNDO;
            8'h12:   o_class.ctrl = CK_REFRESH;
            8'h03:   o_class.ctrl = CK_COPY;
            8'h18:   o_class.ctrl = CK_CUT;
            8'h16:   o_class.ctrl = CK_PASTE;
            8'h01:   o_class.ctrl = CK_SELALL;
            8'h06:   o_class.ctrl = CK_SEARCH;
            8'h0e:   o_class.ctrl = CK_NEXT;
            8'h10:   o_class.ctrl = CK_PREV;
            8'h19:   o_class.ctrl = CK_REDO;
            default: o_class.ctrl = CK_NONE;
        endcase
    end

endmodule

// ===== rtl/tked_queue.sv =====
// Two-entry queue of classified bytes between the front and back ends.
module tked_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  tked_pkg::t_byte_class i_data,
    output logic                  o_full,
    input  logic                  i_pop,
    output logic                  o_empty,
    output tked_pkg::t_byte_class o_data
);
    import tked_pkg::*;

    t_byte_class r_entry [2];
    logic        r_wr_ptr, n_wr_ptr;
    logic        r_rd_ptr, n_rd_ptr;
    logic [1:0]  r_count, n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_entry[r_rd_ptr];

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop  ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== rtl/tked_back.sv =====
// Back end: escape-sequence tracking, search and selection state, result register.
module tked_back #(
    parameter int SEARCH_CAPACITY = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_mouse_en,
    input  logic                  i_indent_en,
    input  logic                  i_q_empty,
    input  tked_pkg::t_byte_class i_q_data,
    output logic                  o_q_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output tked_pkg::t_result     o_result
);
    import tked_pkg::*;

    localparam int LEN_W = $clog2(SEARCH_CAPACITY);
    localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(SEARCH_CAPACITY - 2);

    typedef enum logic [8:0] {
        SQ_IDLE    = 9'b000000001,
        SQ_ESC     = 9'b000000010,
        SQ_BRACKET = 9'b000000100,
        SQ_ONE     = 9'b000001000,
        SQ_SEMI    = 9'b000010000,
        SQ_SHIFT   = 9'b000100000,
        SQ_MBTN    = 9'b001000000,
        SQ_MCOL    = 9'b010000000,
        SQ_MROW    = 9'b100000000
    } t_seq_state;

    t_seq_state       r_seq, n_seq;
    logic [7:0]       r_btn, n_btn;
    logic [7:0]       r_col, n_col;
    logic             r_srch, n_srch;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_sel, n_sel;
    logic             r_valid, n_valid;
    t_result          r_res, n_res;
    logic             done;

    // A request leaves the queue whenever the result register is free or draining.
    assign o_q_pop  = !i_q_empty && (!r_valid || i_ready);
    assign o_valid  = r_valid;
    assign o_result = r_res;

    // Decode one classified byte against the current state.
    always_comb begin
        t_byte_class c;
        c       = i_q_data;
        n_seq   = r_seq;
        n_btn   = r_btn;
        n_col   = r_col;
        n_srch  = r_srch;
        n_len   = r_len;
        n_sel   = r_sel;
        n_res   = '0;
        done    = 1'b0;

        // Search entry takes priority over everything else.
        if (r_srch) begin
            if (c.is_esc) begin
                n_srch = 1'b0; n_len = '0; n_res.kind = EV_CANCEL; done = 1'b1;
            end else if (c.is_crlf) begin
                n_srch = 1'b0; n_len = '0; n_res.kind = EV_SUBMIT; done = 1'b1;
            end else if (c.is_del) begin
                if (r_len != '0) begin
                    n_len = r_len - LEN_W'(1);
                    n_res.kind = EV_SRCH_BACK;
                end
                done = 1'b1;
            end else if (c.is_print) begin
                if (r_len <= LEN_LAST) begin
                    n_len = r_len + LEN_W'(1);
                    n_res.kind = EV_SRCH_APPND;
                    n_res.char_value = c.ch;
                end
                done = 1'b1;
            end
        end

        // Escape and mouse sequence tracking.
        if (!done) begin
            done = 1'b1;
            unique case (r_seq)
                SQ_IDLE: begin
                    if (c.is_esc) n_seq = SQ_ESC;
                    else done = 1'b0;
                end
                SQ_ESC: n_seq = c.is_lbr ? SQ_BRACKET : SQ_IDLE;
                SQ_BRACKET: begin
                    n_seq = SQ_IDLE;
                    if (c.arrow != 3'd0) begin
                        n_sel = 1'b0;
                        n_res.kind = t_event_kind'({2'b00, c.arrow});
                    end else if (c.is_m) begin
                        n_seq = SQ_MBTN;
                    end else if (c.is_one) begin
                        n_seq = SQ_ONE;
                    end
                end
                SQ_ONE:  n_seq = c.is_semi ? SQ_SEMI : SQ_IDLE;
                SQ_SEMI: n_seq = c.is_two ? SQ_SHIFT : SQ_IDLE;
                SQ_SHIFT: begin
                    n_seq = SQ_IDLE;
                    n_sel = 1'b1;
                    n_res.kind = t_event_kind'({2'b00, c.arrow});
                    n_res.extend_selection = (c.arrow != 3'd0);
                end
                SQ_MBTN: begin
                    n_btn = c.ch; n_seq = SQ_MCOL;
                end
                SQ_MCOL: begin
                    n_col = c.ch; n_seq = SQ_MROW;
                end
                SQ_MROW: begin
                    n_seq = SQ_IDLE;
                    if ((r_btn == CH_SPACE) && i_mouse_en) begin
                        n_sel = 1'b0;
                        n_res.kind = EV_CLICK;
                        n_res.click_col = {1'b0, r_col} - MOUSE_OFFSET;
                        n_res.click_row = {1'b0, c.ch} - MOUSE_OFFSET;
                    end
                end
                default: n_seq = SQ_IDLE;
            endcase
        end

        // Control keys and plain characters.
        if (!done) begin
            unique case (c.ctrl)
                CK_QUIT:    n_res.kind = EV_QUIT;
                CK_SAVE:    begin n_sel = 1'b0; n_res.kind = EV_SAVE; end
                CK_UNDO:    begin n_sel = 1'b0; n_res.kind = EV_UNDO; end
                CK_REFRESH: begin n_sel = 1'b0; n_res.kind = EV_REFRESH; end
                CK_COPY: begin
                    if (r_sel) begin n_sel = 1'b0; n_res.kind = EV_COPY; end
                end
                CK_CUT: begin
                    if (r_sel) begin n_sel = 1'b0; n_res.kind = EV_CUT; end
                end
                CK_PASTE: begin
                    n_res.replace_selection = r_sel;
                    n_sel = 1'b0;
                    n_res.kind = EV_PASTE;
                end
                CK_SELALL:  begin n_sel = 1'b1; n_res.kind = EV_SELECTALL; end
                CK_SEARCH: begin
                    n_sel = 1'b0; n_srch = 1'b1; n_len = '0; n_res.kind = EV_SEARCH;
                end
                CK_NEXT:    begin n_sel = 1'b0; n_res.kind = EV_NEXT; end
                CK_PREV:    begin n_sel = 1'b0; n_res.kind = EV_PREV; end
                CK_REDO:    begin n_sel = 1'b0; n_res.kind = EV_REDO; end
                default: begin
                    n_sel = 1'b0;
                    if (c.is_del) begin
                        n_res.kind = EV_DELBACK;
                    end else if (c.is_cr) begin
                        n_res.kind = EV_NEWLINE;
                        n_res.indent_request = i_indent_en;
                    end else if (c.is_ins) begin
                        n_res.kind = EV_INSERT;
                        n_res.char_value = c.ch;
                    end
                end
            endcase
        end

        n_res.selection_active = n_sel;
        n_valid = o_q_pop || (r_valid && !i_ready);
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq   <= SQ_IDLE;
            r_btn   <= '0;
            r_col   <= '0;
            r_srch  <= 1'b0;
            r_len   <= '0;
            r_sel   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (o_q_pop) begin
                r_seq  <= n_seq;
                r_btn  <= n_btn;
                r_col  <= n_col;
                r_srch <= n_srch;
                r_len  <= n_len;
                r_sel  <= n_sel;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_res <= n_res;
        end
    end

endmodule

// ===== rtl/terminal_key_event_decoder_core.sv =====
// Top level of the terminal key event decoder.
//
// Takes one terminal byte per request and returns exactly one event per byte:
// arrows, shift arrows, X10 mouse clicks, control keys, editing and search-entry
// events. A byte is classified on entry, waits in a two-entry queue and is decoded
// by the back end into a result register, so one byte per clock is sustained while
// m_axis_tready is high; the result is offered once the byte has left the queue.
// The back-end decode against sequence, search and selection state sets that rate.
// Configuration writes take effect at once and are meant for idle periods.
module terminal_key_event_decoder_core #(
    parameter int SEARCH_CAPACITY = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic        i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [tked_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // tdata from bit 0: extend_selection, char_value[8], click_col[9], click_row[9],
    // selection_active, replace_selection, indent_request, zero fill
    output logic [4:0]  m_axis_tuser    // [4:0] event_kind
);
    import tked_pkg::*;

    logic        r_mouse_en;
    logic        r_indent_en;
    t_byte_class front_class;
    t_byte_class q_data;
    logic        q_full, q_empty, q_pop, push;
    t_result     result;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mouse_en  <= 1'b1;
            r_indent_en <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MOUSE_EN:  r_mouse_en  <= i_cfg_data;
                CFG_INDENT_EN: r_indent_en <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    assign s_axis_tready = !q_full;
    assign push          = s_axis_tvalid && !q_full;

    tked_front u_front (
        .i_byte  (s_axis_tdata),
        .o_class (front_class)
    );

    tked_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_class),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_data)
    );

    tked_back #(
        .SEARCH_CAPACITY (SEARCH_CAPACITY)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mouse_en  (r_mouse_en),
        .i_indent_en (r_indent_en),
        .i_q_empty   (q_empty),
        .i_q_data    (q_data),
        .o_q_pop     (q_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_result    (result)
    );

    // Result packing.
    assign m_axis_tuser = result.kind;
    assign m_axis_tdata = {2'b00,
                           result.indent_request,
                           result.replace_selection,
                           result.selection_active,
                           result.click_row,
                           result.click_col,
                           result.char_value,
                           result.extend_selection};

endmodule

// ===== rtl/tked_checker.sv =====
// Port-level checks of the terminal key event decoder, bound to the top level.
module tked_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [tked_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [4:0]  m_axis_tuser
);
    import tked_pkg::*;

    // No result is offered right after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Coordinates are zero except on a click.
    a_coords: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != EV_CLICK) |-> (m_axis_tdata[26:9] == '0))
        else $error("coordinates outside a click");

    // A shift arrow is an arrow and leaves the selection active.
    a_extend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |->
            ((m_axis_tuser == EV_UP) || (m_axis_tuser == EV_DOWN) ||
             (m_axis_tuser == EV_RIGHT) || (m_axis_tuser == EV_LEFT)) &&
            m_axis_tdata[27])
        else $error("extend flag outside a shift arrow");

    // Replace and indent flags only come with paste and newline.
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (!m_axis_tdata[28] || (m_axis_tuser == EV_PASTE)) &&
            (!m_axis_tdata[29] || (m_axis_tuser == EV_NEWLINE)))
        else $error("flag on wrong event");

endmodule

bind terminal_key_event_decoder_core tked_checker u_tked_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== test/tb.sv =====
// Self-checking testbench for the terminal key event decoder.
module tb;
    import tked_pkg::*;

    localparam int SRCH_CAP     = 256;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 4;
    localparam int RANDOM_BYTES = 1380;
    localparam int MAX_PRINTS   = 40;

    // Control keys as they arrive from the terminal.
    localparam logic [7:0] KEY_SELALL  = 8'h01;
    localparam logic [7:0] KEY_COPY    = 8'h03;
    localparam logic [7:0] KEY_FIND    = 8'h06;
    localparam logic [7:0] KEY_NEXT    = 8'h0e;
    localparam logic [7:0] KEY_PREV    = 8'h10;
    localparam logic [7:0] KEY_QUIT    = 8'h11;
    localparam logic [7:0] KEY_REFRESH = 8'h12;
    localparam logic [7:0] KEY_SAVE    = 8'h13;
    localparam logic [7:0] KEY_UNDO    = 8'h15;
    localparam logic [7:0] KEY_PASTE   = 8'h16;
    localparam logic [7:0] KEY_CUT     = 8'h18;
    localparam logic [7:0] KEY_REDO    = 8'h19;

    // Escape sequence progress of the predictor.
    typedef enum logic [3:0] {
        PS_IDLE, PS_ESC, PS_BRACKET, PS_ONE, PS_SEMI, PS_SHIFT, PS_MBTN, PS_MCOL, PS_MROW
    } t_parse_state;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic        i_cfg_data = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;    // [7:0] in_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // tdata from bit 0: extend_selection, char_value[8], click_col[9], click_row[9],
    // selection_active, replace_selection, indent_request, zero fill
    logic [4:0]  m_axis_tuser;           // [4:0] event_kind

    // Predictor state and its copy of the configuration.
    t_parse_state parse_st;
    logic [7:0]   btn_byte;
    logic [7:0]   col_byte;
    logic         srch_active;
    int           srch_len;
    logic         sel_flag;
    logic         mouse_en;
    logic         indent_en;

    t_result     pending_events[$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          bytes_sent = 0;
    int          cycle_count = 0;
    logic [24:0] kinds_seen = '0;
    logic        no_idle = 1'b0;

    terminal_key_event_decoder_core #(.SEARCH_CAPACITY(SRCH_CAP)) dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Give up on a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d events still expected",
                     cycle_count, pending_events.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side backpressure.
    always @(negedge i_clk) begin
        m_axis_tready = no_idle || ($urandom_range(99) >= 35);
    end

    task automatic reset_model();
        parse_st    = PS_IDLE;
        btn_byte    = 8'd0;
        col_byte    = 8'd0;
        srch_active = 1'b0;
        srch_len    = 0;
        sel_flag    = 1'b0;
        mouse_en    = 1'b1;
        indent_en   = 1'b1;
    endtask

    // Works out the event caused by one byte and advances the predictor state.
    task automatic decode_key_byte(input logic [7:0] ch, output t_result r);
        logic handled;
        r = '0;
        r.kind = EV_NONE;
        handled = 1'b0;

        // Search entry takes its own bytes first.
        if (srch_active) begin
            if (ch == CH_ESC) begin
                srch_active = 1'b0;
                srch_len = 0;
                r.kind = EV_CANCEL;
                handled = 1'b1;
            end else if (ch == CH_CR || ch == CH_LF) begin
                srch_active = 1'b0;
                srch_len = 0;
                r.kind = EV_SUBMIT;
                handled = 1'b1;
            end else if (ch == CH_BS || ch == CH_DEL) begin
                if (srch_len > 0) begin
                    srch_len--;
                    r.kind = EV_SRCH_BACK;
                end
                handled = 1'b1;
            end else if (ch >= CH_SPACE && ch < CH_DEL) begin
                if (srch_len + 1 < SRCH_CAP) begin
                    srch_len++;
                    r.kind = EV_SRCH_APPND;
                    r.char_value = ch;
                end
                handled = 1'b1;
            end
        end

        // Escape sequences.
        if (!handled) begin
            handled = 1'b1;
            case (parse_st)
                PS_IDLE: begin
                    if (ch == CH_ESC) parse_st = PS_ESC;
                    else handled = 1'b0;
                end
                PS_ESC: parse_st = (ch == CH_LBR) ? PS_BRACKET : PS_IDLE;
                PS_BRACKET: begin
                    parse_st = PS_IDLE;
                    if (ch >= CH_A && ch <= CH_D) begin
                        sel_flag = 1'b0;
                        r.kind = t_event_kind'(EV_UP + (ch - CH_A));
                    end else if (ch == CH_M) begin
                        parse_st = PS_MBTN;
                    end else if (ch == CH_ONE) begin
                        parse_st = PS_ONE;
                    end
                end
                PS_ONE: parse_st = (ch == CH_SEMI) ? PS_SEMI : PS_IDLE;
                PS_SEMI: parse_st = (ch == CH_TWO) ? PS_SHIFT : PS_IDLE;
                PS_SHIFT: begin
                    parse_st = PS_IDLE;
                    sel_flag = 1'b1;
                    if (ch >= CH_A && ch <= CH_D) begin
                        r.kind = t_event_kind'(EV_UP + (ch - CH_A));
                        r.extend_selection = 1'b1;
                    end
                end
                PS_MBTN: begin
                    btn_byte = ch;
                    parse_st = PS_MCOL;
                end
                PS_MCOL: begin
                    col_byte = ch;
                    parse_st = PS_MROW;
                end
                default: begin
                    parse_st = PS_IDLE;
                    if (btn_byte == CH_SPACE && mouse_en) begin
                        sel_flag = 1'b0;
                        r.kind = EV_CLICK;
                        r.click_col = {1'b0, col_byte} - MOUSE_OFFSET;
                        r.click_row = {1'b0, ch} - MOUSE_OFFSET;
                    end
                end
            endcase
        end

        // Control keys, editing keys and text.
        if (!handled) begin
            case (ch)
                KEY_QUIT: r.kind = EV_QUIT;
                KEY_SAVE: begin sel_flag = 1'b0; r.kind = EV_SAVE; end
                KEY_UNDO: begin sel_flag = 1'b0; r.kind = EV_UNDO; end
                KEY_REFRESH: begin sel_flag = 1'b0; r.kind = EV_REFRESH; end
                KEY_COPY: begin
                    if (sel_flag) begin
                        sel_flag = 1'b0;
                        r.kind = EV_COPY;
                    end
                end
                KEY_CUT: begin
                    if (sel_flag) begin
                        sel_flag = 1'b0;
                        r.kind = EV_CUT;
                    end
                end
                KEY_PASTE: begin
                    r.replace_selection = sel_flag;
                    sel_flag = 1'b0;
                    r.kind = EV_PASTE;
                end
                KEY_SELALL: begin sel_flag = 1'b1; r.kind = EV_SELECTALL; end
                KEY_FIND: begin
                    sel_flag = 1'b0;
                    srch_active = 1'b1;
                    srch_len = 0;
                    r.kind = EV_SEARCH;
                end
                KEY_NEXT: begin sel_flag = 1'b0; r.kind = EV_NEXT; end
                KEY_PREV: begin sel_flag = 1'b0; r.kind = EV_PREV; end
                KEY_REDO: begin sel_flag = 1'b0; r.kind = EV_REDO; end
                default: begin
                    sel_flag = 1'b0;
                    if (ch == CH_BS || ch == CH_DEL) begin
                        r.kind = EV_DELBACK;
                    end else if (ch == CH_CR) begin
                        r.kind = EV_NEWLINE;
                        r.indent_request = indent_en;
                    end else if (ch >= CH_SPACE || ch == CH_TAB || ch == CH_LF) begin
                        r.kind = EV_INSERT;
                        r.char_value = ch;
                    end
                end
            endcase
        end
        r.selection_active = sel_flag;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("Result %0d: %s is %0d, expected %0d", results_seen, what, got, want);
    endtask

    // Compare every accepted result with the oldest expected event.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            kinds_seen[m_axis_tuser] = 1'b1;
            if (pending_events.size() == 0) begin
                report_mismatch("unexpected result, kind", m_axis_tuser, 0);
            end else begin
                want = pending_events.pop_front();
                if (m_axis_tuser != want.kind)
                    report_mismatch("event_kind", m_axis_tuser, want.kind);
                if (m_axis_tdata[0] != want.extend_selection)
                    report_mismatch("extend_selection", m_axis_tdata[0], want.extend_selection);
                if (m_axis_tdata[8:1] != want.char_value)
                    report_mismatch("char_value", m_axis_tdata[8:1], want.char_value);
                if (m_axis_tdata[17:9] != want.click_col)
                    report_mismatch("click_col", m_axis_tdata[17:9], want.click_col);
                if (m_axis_tdata[26:18] != want.click_row)
                    report_mismatch("click_row", m_axis_tdata[26:18], want.click_row);
                if (m_axis_tdata[27] != want.selection_active)
                    report_mismatch("selection_active", m_axis_tdata[27], want.selection_active);
                if (m_axis_tdata[28] != want.replace_selection)
                    report_mismatch("replace_selection", m_axis_tdata[28],
                                    want.replace_selection);
                if (m_axis_tdata[29] != want.indent_request)
                    report_mismatch("indent_request", m_axis_tdata[29], want.indent_request);
            end
            results_seen++;
        end
    end

    // Offer one byte, with a random gap ahead of it, and log its expected event.
    task automatic send_byte(input logic [7:0] b);
        t_result want;
        @(negedge i_clk);
        while (!no_idle && $urandom_range(99) < 35) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        decode_key_byte(b, want);
        pending_events.push_back(want);
        bytes_sent++;
    endtask

    // Hold off requests until every expected event has come back.
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_cfg(input t_cfg_idx idx, input logic v);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_MOUSE_EN) mouse_en = v;
        else indent_en = v;
    endtask

    task automatic send_mouse(input logic [7:0] btn, input logic [7:0] col,
                              input logic [7:0] row);
        send_byte(CH_ESC); send_byte(CH_LBR); send_byte(CH_M);
        send_byte(btn); send_byte(col); send_byte(row);
    endtask

    task automatic send_shift(input logic [7:0] last);
        send_byte(CH_ESC); send_byte(CH_LBR); send_byte(CH_ONE);
        send_byte(CH_SEMI); send_byte(CH_TWO); send_byte(last);
    endtask

    function automatic logic [7:0] ctrl_key_at(input int k);
        case (k)
            0: return KEY_SELALL;
            1: return KEY_COPY;
            2: return KEY_FIND;
            3: return KEY_NEXT;
            4: return KEY_PREV;
            5: return KEY_QUIT;
            6: return KEY_REFRESH;
            7: return KEY_SAVE;
            8: return KEY_UNDO;
            9: return KEY_PASTE;
            10: return KEY_CUT;
            default: return KEY_REDO;
        endcase
    endfunction

    // Every control key but search; copy, cut and paste with and without a selection; the byte extremes.
    task automatic test_keys();
        send_byte(KEY_COPY); send_byte(KEY_CUT); send_byte(KEY_PASTE);
        send_byte(KEY_SELALL); send_byte(KEY_COPY);
        send_byte(KEY_SELALL); send_byte(KEY_CUT);
        send_byte(KEY_SELALL); send_byte(KEY_QUIT); send_byte(KEY_PASTE);
        send_byte(KEY_SAVE); send_byte(KEY_UNDO); send_byte(KEY_REFRESH);
        send_byte(KEY_NEXT); send_byte(KEY_PREV); send_byte(KEY_REDO);
        send_byte(CH_BS); send_byte(CH_DEL); send_byte(CH_CR); send_byte(CH_LF);
        send_byte(CH_TAB); send_byte(8'h00); send_byte(8'h1f); send_byte(CH_SPACE);
        send_byte(8'h7e); send_byte(8'h80); send_byte(8'hff);
    endtask

    // Arrows, shift arrows, mouse reports and broken sequences.
    task automatic test_sequences();
        logic [7:0] a;
        send_byte(KEY_SELALL);
        for (a = CH_A; a <= CH_D; a++) begin
            send_byte(CH_ESC); send_byte(CH_LBR); send_byte(a);
        end
        for (a = CH_A; a <= CH_D; a++) send_shift(a);
        send_shift(8'h5a);
        send_byte(CH_ESC); send_byte(8'h78);
        send_byte(CH_ESC); send_byte(CH_ESC);
        send_byte(CH_ESC); send_byte(CH_LBR); send_byte(8'h5a);
        send_byte(CH_ESC); send_byte(CH_LBR); send_byte(CH_ONE); send_byte(8'h78);
        send_byte(CH_ESC); send_byte(CH_LBR); send_byte(CH_ONE); send_byte(CH_SEMI);
        send_byte(8'h33);
        send_byte(KEY_SELALL);
        send_mouse(CH_SPACE, CH_SPACE, CH_SPACE);
        send_mouse(CH_SPACE, 8'h00, 8'hff);
        send_mouse(CH_SPACE, 8'hff, 8'h00);
        send_mouse(8'h21, 8'h64, 8'h64);
    endtask

    // Search entry: cancel, both submit bytes, empty backspace and the length bound.
    task automatic test_search();
        send_byte(KEY_SELALL); send_byte(KEY_FIND);
        send_byte(8'h61); send_byte(CH_BS); send_byte(CH_DEL);
        send_byte(8'h80); send_byte(KEY_SELALL); send_byte(8'h7e); send_byte(CH_ESC);
        send_byte(KEY_FIND); send_byte(8'h78); send_byte(CH_CR);
        send_byte(KEY_FIND); send_byte(CH_LF);
        send_byte(KEY_FIND);
        repeat (SRCH_CAP + 2) send_byte(8'($urandom_range(32, 126)));
        send_byte(CH_DEL); send_byte(8'h41); send_byte(8'h42); send_byte(CH_CR);
    endtask

    // Both registers at both values, each checked with a click and a newline.
    task automatic test_config();
        int m;
        for (m = 0; m < 4; m++) begin
            wait_idle();
            write_cfg(CFG_MOUSE_EN, m[0]);
            write_cfg(CFG_INDENT_EN, m[1]);
            send_byte(CH_CR);
            send_mouse(CH_SPACE, 8'h2a, 8'hc0);
            send_byte(CH_LF);
        end
    endtask

    // One random burst: mostly well-formed sequences, some noise.
    task automatic send_random_group();
        int pick;
        int n;
        int k;
        logic [7:0] b;
        pick = $urandom_range(0, 19);
        if (pick < 2) begin
            send_byte(CH_ESC); send_byte(CH_LBR);
            send_byte(8'($urandom_range(CH_A, CH_D)));
        end else if (pick < 4) begin
            b = ($urandom_range(3) != 0) ? 8'($urandom_range(CH_A, CH_D)) : 8'($urandom);
            send_shift(b);
        end else if (pick < 7) begin
            b = ($urandom_range(3) != 0) ? CH_SPACE : 8'($urandom);
            send_mouse(b, 8'($urandom), 8'($urandom));
        end else if (pick < 9) begin
            send_byte(KEY_FIND);
            n = $urandom_range(0, 15);
            repeat (n) begin
                k = $urandom_range(0, 9);
                if (k < 6) send_byte(8'($urandom_range(32, 126)));
                else if (k < 8) send_byte(k[0] ? CH_BS : CH_DEL);
                else send_byte(8'($urandom));
            end
            k = $urandom_range(0, 3);
            if (k == 0) send_byte(CH_ESC);
            else if (k == 1) send_byte(CH_CR);
            else if (k == 2) send_byte(CH_LF);
        end else if (pick < 11) begin
            send_byte(ctrl_key_at($urandom_range(0, 11)));
        end else if (pick == 11) begin
            if ($urandom_range(1)) send_byte(KEY_SELALL);
            k = $urandom_range(0, 2);
            send_byte(k == 0 ? KEY_COPY : (k == 1 ? KEY_CUT : KEY_PASTE));
        end else if (pick < 14) begin
            send_byte(8'($urandom_range(32, 126)));
        end else if (pick < 16) begin
            send_byte(8'($urandom));
        end else if (pick < 18) begin
            // A sequence cut short by an arbitrary byte.
            n = $urandom_range(1, 4);
            send_byte(CH_ESC);
            if (n >= 2) send_byte(CH_LBR);
            if (n >= 3) send_byte(CH_ONE);
            if (n >= 4) send_byte(CH_SEMI);
            send_byte(8'($urandom));
        end else if (pick == 18) begin
            k = $urandom_range(0, 4);
            case (k)
                0: send_byte(CH_CR);
                1: send_byte(CH_BS);
                2: send_byte(CH_DEL);
                3: send_byte(CH_LF);
                default: send_byte(CH_TAB);
            endcase
        end else begin
            send_byte(CH_ESC); send_byte(8'($urandom));
        end
    endtask

    // Random traffic in phases, with fresh settings between them.
    task automatic test_random();
        int start;
        int phase_end;
        start = bytes_sent;
        phase_end = start + 450;
        while (bytes_sent - start < RANDOM_BYTES) begin
            no_idle = (bytes_sent - start >= 600) && (bytes_sent - start < 900);
            send_random_group();
            if (bytes_sent >= phase_end) begin
                wait_idle();
                write_cfg(CFG_MOUSE_EN, 1'($urandom));
                write_cfg(CFG_INDENT_EN, 1'($urandom));
                phase_end = bytes_sent + 450;
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        reset_model();
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_keys();
        test_sequences();
        test_search();
        test_config();
        test_random();
        wait_idle();

        $display("Checked %0d results for %0d bytes; %0d of 25 event kinds were seen.",
                 results_seen, bytes_sent, $countones(kinds_seen));
        $display("Covered control keys, arrows, shift arrows, mouse reports, search entry.");
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/tked_pkg.sv
rtl/tked_front.sv
rtl/tked_queue.sv
rtl/tked_back.sv
rtl/terminal_key_event_decoder_core.sv
rtl/tked_checker.sv
test/tb.sv
